// File: rtl/core/sse_pkg.sv
`timescale 1ns / 1ps

package sse_pkg;

    localparam int MaxSamples = 1024;
    localparam int AddrW      = $clog2(MaxSamples);
    localparam int CntW       = AddrW + 1;
    localparam int SampleW    = 16;
    localparam int SumW       = 26;
    localparam int SumSqW     = 42;
    localparam int AccW       = SumSqW + CntW;
    localparam int DevW       = 52;
    localparam int DvdW       = DevW + 16;
    localparam int DivW       = 2 * AddrW + 1;
    localparam int VarW       = 48;
    localparam int QW         = 24;
    localparam int PctW       = 7;
    localparam int PxW        = 17;
    localparam int NumPct     = 4;
    localparam int OutDataW   = 184;

    // floor(x/100) == (x * RecipPct) >> RecipShift for every x below 2**17
    localparam logic [17:0] RecipPct   = 18'd167773;
    localparam int          RecipShift = 24;

    typedef enum logic [1:0] {
        FN_ADD    = 2'd0,
        FN_FINISH = 2'd1,
        FN_CLEAR  = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        CFG_IN_USE = 3'd0,
        CFG_PCT_A  = 3'd1,
        CFG_PCT_B  = 3'd2,
        CFG_PCT_C  = 3'd3,
        CFG_PCT_D  = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_MDIV,
        S_VDIV,
        S_SQRT,
        S_PIDX_A,
        S_PIDX_B,
        S_CAND,
        S_CANDW,
        S_SCAN,
        S_SCANW,
        S_EVAL,
        S_DONE
    } t_state;

endpackage

// File: rtl/core/sample_statistics_engine_unit.sv
`timescale 1ns / 1ps
// Add and clear words: one per cycle while idle, no result; none are taken during a finish.
// Finish steps in order: n*sum_sq, mean divide, variance divide, sqrt,
//   percentile index, then rank selection over the sample RAM (one RAM
//   read port); an empty set skips these steps and goes straight to the result.
// Adds and clears are taken while a finished result waits on the output.
// Reset (sync, active low) empties the set, restores config; sample RAM left as is.

module sample_statistics_engine_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [sse_pkg::SampleW-1:0]   i_s_tdata,   // [15:0] sample
    input  logic [1:0]                    i_s_tuser,   // [1:0] func
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [10:0] sample_count, [26:11] min_value, [42:27] max_value, [68:43] total,
    // [92:69] mean_q8, [116:93] std_dev_q8, [132:117] pct_value_a,
    // [148:133] pct_value_b, [164:149] pct_value_c, [180:165] pct_value_d, rest 0
    output logic [sse_pkg::OutDataW-1:0]  o_m_tdata,
    output logic [0:0]                    o_m_tuser,   // [0] set_valid
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [2:0]                    i_cfg_index,
    input  logic [6:0]                    i_cfg_data
);
    import sse_pkg::*;

    t_state r_state, n_state;

    // set statistics
    logic [CntW-1:0]    r_count;
    logic [SampleW-1:0] r_min, r_max;
    logic [SumW-1:0]    r_sum;
    logic [SumSqW-1:0]  r_sumsq;

    // config
    logic [2:0]      r_in_use;
    logic [PctW-1:0] r_pct [NumPct];

    // sample RAM
    logic [SampleW-1:0] r_mem [MaxSamples];
    logic [SampleW-1:0] r_rdata;
    logic [AddrW-1:0]   rd_addr;
    logic               s_ready;

    // finish datapath
    logic [6:0]         r_cnt;
    logic [AccW-1:0]    r_acc;
    logic [DevW-1:0]    r_sum2;
    logic [DivW-1:0]    r_n2;
    logic [DvdW-1:0]    r_dvd;
    logic [DivW-1:0]    r_rem;
    logic [DivW-1:0]    r_div;
    logic [QW-1:0]      r_mean, r_std;
    logic [VarW-1:0]    r_sx, r_res, r_bit;
    logic [1:0]         r_pk;
    logic [PxW-1:0]     r_px;
    logic [CntW-1:0]    r_pidx [NumPct];
    logic [AddrW-1:0]   r_ci, r_sj, r_last;
    logic [SampleW-1:0] r_cand;
    logic [CntW-1:0]    r_lt, r_le;
    logic               r_rv;
    logic [SampleW-1:0] r_pval [NumPct];

    logic               r_ovld;
    logic [OutDataW-1:0] r_odata;
    logic               r_ouser;

    logic               s_acc;
    t_func              s_func;
    logic               done_load;

    // divider step
    logic [DivW:0]      rem_sh;
    logic               div_ge;
    logic [DivW-1:0]    rem_nx;
    logic [DvdW-1:0]    dvd_nx;
    logic [DevW-1:0]    dev;

    // sqrt step
    logic [VarW-1:0]    sq_t;
    logic               sq_ge;
    logic [VarW-1:0]    res_nx;

    logic [PxW+17:0]    pprod;
    logic [CntW-1:0]    pq, nm1;
    logic [2:0]         act;

    assign s_func    = t_func'(i_s_tuser);
    assign s_acc     = i_s_tvalid && s_ready;
    assign done_load = (r_state == S_DONE) && (!r_ovld || i_m_tready);

    assign rem_sh = {r_rem, r_dvd[DvdW-1]};
    assign div_ge = rem_sh >= {1'b0, r_div};
    assign rem_nx = div_ge ? DivW'(rem_sh - {1'b0, r_div}) : rem_sh[DivW-1:0];
    assign dvd_nx = {r_dvd[DvdW-2:0], div_ge};
    assign dev    = DevW'(r_acc - {1'b0, r_sum2});

    assign sq_t   = r_res + r_bit;
    assign sq_ge  = r_sx >= sq_t;
    assign res_nx = sq_ge ? (r_res >> 1) + r_bit : r_res >> 1;

    assign pprod  = {1'b0, r_px} * RecipPct;
    assign pq     = pprod[RecipShift+CntW-1:RecipShift];
    assign nm1    = r_count - CntW'(1);
    assign act    = (r_in_use > 3'd4) ? 3'd4 : r_in_use;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc && s_func == FN_FINISH) begin
                    n_state = (r_count == '0) ? S_DONE : S_MUL;
                end
            end
            S_MUL:    if (r_cnt == 7'(CntW - 1)) n_state = S_MDIV;
            S_MDIV:   if (r_cnt == 7'(DvdW - 1)) n_state = S_VDIV;
            S_VDIV:   if (r_cnt == 7'(DvdW - 1)) n_state = S_SQRT;
            S_SQRT:   if (r_cnt == 7'(VarW / 2 - 1)) n_state = S_PIDX_A;
            S_PIDX_A: n_state = S_PIDX_B;
            S_PIDX_B: n_state = (r_pk == 2'(NumPct - 1)) ? S_CAND : S_PIDX_A;
            S_CAND:   n_state = S_CANDW;
            S_CANDW:  n_state = S_SCAN;
            S_SCAN:   if (r_sj == r_last) n_state = S_SCANW;
            S_SCANW:  n_state = S_EVAL;
            S_EVAL:   n_state = (r_ci == r_last) ? S_DONE : S_CAND;
            S_DONE:   if (done_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready = 1'b0;
        rd_addr = r_sj;
        case (r_state)
            S_IDLE:  s_ready = 1'b1;
            S_CAND:  rd_addr = r_ci;
            default: begin
                s_ready = 1'b0;
                rd_addr = r_sj;
            end
        endcase
    end

    // sample RAM, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (s_acc && s_func == FN_ADD && !r_count[AddrW]) begin
            r_mem[r_count[AddrW-1:0]] <= i_s_tdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // control and set statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_min    <= '1;
            r_max    <= '0;
            r_sum    <= '0;
            r_sumsq  <= '0;
            r_in_use <= '0;
            r_pct[0] <= 7'd25;
            r_pct[1] <= 7'd50;
            r_pct[2] <= 7'd75;
            r_pct[3] <= 7'd90;
            r_ovld   <= 1'b0;
            r_rv     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rv    <= (r_state == S_SCAN);
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_IN_USE: r_in_use <= i_cfg_data[2:0];
                    CFG_PCT_A:  r_pct[0] <= i_cfg_data;
                    CFG_PCT_B:  r_pct[1] <= i_cfg_data;
                    CFG_PCT_C:  r_pct[2] <= i_cfg_data;
                    CFG_PCT_D:  r_pct[3] <= i_cfg_data;
                    default:    ;
                endcase
            end
            if (s_acc) begin
                case (s_func)
                    FN_ADD: begin
                        if (!r_count[AddrW]) begin
                            r_count <= r_count + CntW'(1);
                            if (i_s_tdata < r_min) r_min <= i_s_tdata;
                            if (i_s_tdata > r_max) r_max <= i_s_tdata;
                            r_sum   <= r_sum + SumW'(i_s_tdata);
                            r_sumsq <= r_sumsq + SumSqW'({16'd0, i_s_tdata} *
                                                         {16'd0, i_s_tdata});
                        end
                    end
                    FN_CLEAR: begin
                        r_count <= '0;
                        r_min   <= '1;
                        r_max   <= '0;
                        r_sum   <= '0;
                        r_sumsq <= '0;
                    end
                    default: ;
                endcase
            end
            if (done_load) begin
                r_ovld <= 1'b1;
            end else if (i_m_tready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // finish datapath
    always_ff @(posedge i_clk) begin
        if (r_rv) begin
            if (r_rdata < r_cand)  r_lt <= r_lt + CntW'(1);
            if (r_rdata <= r_cand) r_le <= r_le + CntW'(1);
        end
        case (r_state)
            S_IDLE: begin
                r_cnt  <= '0;
                r_acc  <= '0;
                r_sum2 <= {{SumW{1'b0}}, r_sum} * {{SumW{1'b0}}, r_sum};
                r_n2   <= DivW'({{CntW{1'b0}}, r_count} * {{CntW{1'b0}}, r_count});
                r_ci   <= '0;
                r_pk   <= '0;
                r_last <= nm1[AddrW-1:0];
                for (int k = 0; k < NumPct; k++) r_pval[k] <= '0;
            end
            S_MUL: begin
                // n * sum_sq by shift and add over the bits of n
                if (r_count[r_cnt[3:0]]) begin
                    r_acc <= r_acc + ({{CntW{1'b0}}, r_sumsq} << r_cnt[3:0]);
                end
                if (r_cnt == 7'(CntW - 1)) begin
                    r_cnt <= '0;
                    r_dvd <= {{(DvdW-SumW-8){1'b0}}, r_sum, 8'd0};
                    r_rem <= '0;
                    r_div <= {{(DivW-CntW){1'b0}}, r_count};
                end else begin
                    r_cnt <= r_cnt + 7'd1;
                end
            end
            S_MDIV: begin
                if (r_cnt == 7'(DvdW - 1)) begin
                    r_cnt  <= '0;
                    r_mean <= dvd_nx[QW-1:0];
                    r_dvd  <= {dev, 16'd0};
                    r_rem  <= '0;
                    r_div  <= r_n2;
                end else begin
                    r_dvd <= dvd_nx;
                    r_rem <= rem_nx;
                    r_cnt <= r_cnt + 7'd1;
                end
            end
            S_VDIV: begin
                r_dvd <= dvd_nx;
                r_rem <= rem_nx;
                if (r_cnt == 7'(DvdW - 1)) begin
                    r_cnt <= '0;
                    r_sx  <= dvd_nx[VarW-1:0];
                    r_res <= '0;
                    r_bit <= {2'b01, {(VarW-2){1'b0}}};
                end else begin
                    r_cnt <= r_cnt + 7'd1;
                end
            end
            S_SQRT: begin
                if (sq_ge) r_sx <= r_sx - sq_t;
                r_res <= res_nx;
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(VarW / 2 - 1)) r_std <= res_nx[QW-1:0];
            end
            S_PIDX_A: begin
                r_px <= PxW'({6'd0, r_count} * {{(PxW-PctW){1'b0}}, r_pct[r_pk]}) + PxW'(99);
            end
            S_PIDX_B: begin
                r_pidx[r_pk] <= (pq > nm1) ? nm1 : pq;
                r_pk <= r_pk + 2'd1;
            end
            S_CANDW: begin
                r_cand <= r_rdata;
                r_lt   <= '0;
                r_le   <= '0;
                r_sj   <= '0;
            end
            S_SCAN: begin
                if (r_sj != r_last) r_sj <= r_sj + AddrW'(1);
            end
            S_EVAL: begin
                // candidate covers sorted ranks lt .. le-1
                for (int k = 0; k < NumPct; k++) begin
                    if (r_lt <= r_pidx[k] && r_pidx[k] < r_le) r_pval[k] <= r_cand;
                end
                r_ci <= r_ci + AddrW'(1);
            end
            default: ;
        endcase
        if (done_load) begin
            if (r_count == '0) begin
                r_odata <= '0;
                r_ouser <= 1'b0;
            end else begin
                r_ouser <= 1'b1;
                r_odata <= {3'd0,
                            (act > 3'd3) ? r_pval[3] : 16'd0,
                            (act > 3'd2) ? r_pval[2] : 16'd0,
                            (act > 3'd1) ? r_pval[1] : 16'd0,
                            (act > 3'd0) ? r_pval[0] : 16'd0,
                            r_std, r_mean, r_sum, r_max, r_min, r_count};
            end
        end
    end

    assign o_s_tready  = s_ready;
    assign o_m_tvalid  = r_ovld;
    assign o_m_tdata   = r_odata;
    assign o_m_tuser   = r_ouser;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MaxSamples))
        else $error("sample count beyond store depth");
    a_rank_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EVAL |-> r_le > r_lt)
        else $error("candidate not counted in its own scan");
    a_empty_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && s_func == FN_FINISH && r_count == '0 |=> r_state == S_DONE)
        else $error("empty finish did not go to done");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_s_tready)
        else $error("input taken during finish");
`endif

endmodule

// File: tb/tb_sample_statistics_engine_unit.sv
`timescale 1ns / 1ps

module tb_sample_statistics_engine_unit;
    import sse_pkg::*;

    typedef struct packed {
        logic        set_valid;
        logic [10:0] sample_count;
        logic [15:0] min_value;
        logic [15:0] max_value;
        logic [25:0] total;
        logic [23:0] mean_q8;
        logic [23:0] std_dev_q8;
        logic [15:0] pct_value_a;
        logic [15:0] pct_value_b;
        logic [15:0] pct_value_c;
        logic [15:0] pct_value_d;
    } t_report;

    typedef struct packed {
        t_func       func;
        logic [15:0] sample;
    } t_word;

    // DUT ports
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [SampleW-1:0]   i_s_tdata;
    logic [1:0]           i_s_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [OutDataW-1:0]  o_m_tdata;
    logic [0:0]           o_m_tuser;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [2:0]           i_cfg_index;
    logic [6:0]           i_cfg_data;

    sample_statistics_engine_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the block's set and config
    logic [15:0] shadow_store [MaxSamples];
    int unsigned shadow_count;
    logic [15:0] shadow_min;
    logic [15:0] shadow_max;
    longint unsigned shadow_sum;
    longint unsigned shadow_sum_sq;
    logic [2:0]  shadow_in_use;
    logic [6:0]  shadow_pct [NumPct];

    t_word   pending_words[$];
    t_report expected_reports[$];

    int  error_count;
    int  cycle_count;
    int  report_count;
    int  send_gap;
    int  recv_gap;
    bit  hold_sender;   // drained-pipe pause

    // Integer square root, bit-by-bit
    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Apply one accepted word to the shadow set; queue a report on finish
    task automatic apply_word(t_word w);
        t_report r;
        longint unsigned n;
        longint unsigned n2;
        longint unsigned dev;
        longint unsigned var_q16;
        longint unsigned idx;
        logic [15:0] sorted [$];
        int active;
        case (w.func)
            FN_ADD: begin
                if (shadow_count < MaxSamples) begin
                    shadow_store[shadow_count] = w.sample;
                    shadow_count++;
                    if (w.sample < shadow_min) shadow_min = w.sample;
                    if (w.sample > shadow_max) shadow_max = w.sample;
                    shadow_sum += w.sample;
                    shadow_sum_sq += longint'(w.sample) * w.sample;
                end
            end
            FN_CLEAR: begin
                shadow_count = 0;
                shadow_min = '1;
                shadow_max = '0;
                shadow_sum = 0;
                shadow_sum_sq = 0;
            end
            FN_FINISH: begin
                r = '0;
                if (shadow_count != 0) begin
                    n = shadow_count;
                    n2 = n * n;
                    dev = n * shadow_sum_sq - shadow_sum * shadow_sum;
                    var_q16 = (dev / n2) * 65536 + ((dev % n2) * 65536) / n2;
                    r.set_valid = 1'b1;
                    r.sample_count = n[10:0];
                    r.min_value = shadow_min;
                    r.max_value = shadow_max;
                    r.total = shadow_sum[25:0];
                    r.mean_q8 = 24'((shadow_sum * 256) / n);
                    r.std_dev_q8 = 24'(int_sqrt(var_q16));
                    for (int i = 0; i < shadow_count; i++) begin
                        sorted.insert(sorted.size(), shadow_store[i]);
                    end
                    sorted.sort();
                    active = (shadow_in_use > 4) ? 4 : shadow_in_use;
                    for (int k = 0; k < active; k++) begin
                        idx = (n * shadow_pct[k] + 99) / 100;
                        if (idx > n - 1) idx = n - 1;
                        case (k)
                            0: r.pct_value_a = sorted[idx];
                            1: r.pct_value_b = sorted[idx];
                            2: r.pct_value_c = sorted[idx];
                            default: r.pct_value_d = sorted[idx];
                        endcase
                    end
                end
                expected_reports.insert(expected_reports.size(), r);
            end
            default: ;  // unused code: ignored
        endcase
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: one word from the queue per handshake, random gap per word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (i_s_tvalid && o_s_tready) begin
            apply_word(pending_words.pop_front());
            i_s_tvalid <= 1'b0;
            send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
        end else if (!i_s_tvalid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_words.size() != 0 && !hold_sender) begin
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= pending_words[0].func;
                i_s_tdata  <= pending_words[0].sample;
            end
        end
    end

    // Monitor: checks each report against the oldest expected one
    always @(posedge i_clk) begin
        t_report got;
        t_report exp_r;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got = '0;
                got.set_valid    = o_m_tuser[0];
                got.sample_count = o_m_tdata[10:0];
                got.min_value    = o_m_tdata[26:11];
                got.max_value    = o_m_tdata[42:27];
                got.total        = o_m_tdata[68:43];
                got.mean_q8      = o_m_tdata[92:69];
                got.std_dev_q8   = o_m_tdata[116:93];
                got.pct_value_a  = o_m_tdata[132:117];
                got.pct_value_b  = o_m_tdata[148:133];
                got.pct_value_c  = o_m_tdata[164:149];
                got.pct_value_d  = o_m_tdata[180:165];
                report_count++;
                if (expected_reports.size() == 0) begin
                    $error("unexpected report word");
                    error_count++;
                end else begin
                    exp_r = expected_reports.pop_front();
                    if (got.set_valid !== exp_r.set_valid) begin
                        $error("set_valid exp %0d got %0d", exp_r.set_valid, got.set_valid);
                        error_count++;
                    end
                    if (got.sample_count !== exp_r.sample_count) begin
                        $error("sample_count exp %0d got %0d",
                               exp_r.sample_count, got.sample_count);
                        error_count++;
                    end
                    if (got.min_value !== exp_r.min_value) begin
                        $error("min_value exp %0d got %0d", exp_r.min_value, got.min_value);
                        error_count++;
                    end
                    if (got.max_value !== exp_r.max_value) begin
                        $error("max_value exp %0d got %0d", exp_r.max_value, got.max_value);
                        error_count++;
                    end
                    if (got.total !== exp_r.total) begin
                        $error("total exp %0d got %0d", exp_r.total, got.total);
                        error_count++;
                    end
                    if (got.mean_q8 !== exp_r.mean_q8) begin
                        $error("mean_q8 exp %0d got %0d", exp_r.mean_q8, got.mean_q8);
                        error_count++;
                    end
                    if (got.std_dev_q8 !== exp_r.std_dev_q8) begin
                        $error("std_dev_q8 exp %0d got %0d",
                               exp_r.std_dev_q8, got.std_dev_q8);
                        error_count++;
                    end
                    if (got.pct_value_a !== exp_r.pct_value_a) begin
                        $error("pct_value_a exp %0d got %0d",
                               exp_r.pct_value_a, got.pct_value_a);
                        error_count++;
                    end
                    if (got.pct_value_b !== exp_r.pct_value_b) begin
                        $error("pct_value_b exp %0d got %0d",
                               exp_r.pct_value_b, got.pct_value_b);
                        error_count++;
                    end
                    if (got.pct_value_c !== exp_r.pct_value_c) begin
                        $error("pct_value_c exp %0d got %0d",
                               exp_r.pct_value_c, got.pct_value_c);
                        error_count++;
                    end
                    if (got.pct_value_d !== exp_r.pct_value_d) begin
                        $error("pct_value_d exp %0d got %0d",
                               exp_r.pct_value_d, got.pct_value_d);
                        error_count++;
                    end
                end
            end
            // ready pattern: random stall length per word, sometimes none
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_m_tready <= 1'b0;
            end else if (o_m_tvalid && i_m_tready) begin
                recv_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Watchdog. Largest set is 80 samples.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1000000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [6:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_IN_USE: shadow_in_use = val[2:0];
            CFG_PCT_A:  shadow_pct[0] = val;
            CFG_PCT_B:  shadow_pct[1] = val;
            CFG_PCT_C:  shadow_pct[2] = val;
            default:    shadow_pct[3] = val;
        endcase
    endtask

    task automatic push(t_func f, logic [15:0] s);
        t_word w;
        w.func = f;
        w.sample = s;
        pending_words.insert(pending_words.size(), w);
    endtask

    // Wait until the driver has sent everything and every report is back
    task automatic drain();
        while (pending_words.size() != 0 || i_s_tvalid || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // A well-formed set: clear, n adds of a chosen style (now and then an unused-code word), finish
    task automatic queue_set(int n);
        int style;
        style = $urandom_range(0, 3);
        push(FN_CLEAR, 16'($urandom));
        for (int i = 0; i < n; i++) begin
            case (style)
                0: push(FN_ADD, 16'($urandom));
                1: push(FN_ADD, 16'($urandom_range(0, 7)));
                2: push(FN_ADD, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
                default: push(FN_ADD, 16'hFFF0 + 16'($urandom_range(0, 15)));
            endcase
            if ($urandom_range(0, 40) == 0) push(FN_NONE, 16'($urandom));
        end
        push(FN_FINISH, 16'($urandom));
    endtask

    initial begin
        int items;
        error_count = 0;
        cycle_count = 0;
        report_count = 0;
        hold_sender = 0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        i_m_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_IN_USE;
        i_cfg_data = '0;
        shadow_in_use = 3'd0;
        shadow_pct[0] = 7'd25;
        shadow_pct[1] = 7'd50;
        shadow_pct[2] = 7'd75;
        shadow_pct[3] = 7'd90;
        shadow_count = 0;
        shadow_min = '1;
        shadow_max = '0;
        shadow_sum = 0;
        shadow_sum_sq = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty finish at reset config, then extremes
        push(FN_FINISH, 16'h0000);
        push(FN_ADD, 16'hFFFF);
        push(FN_FINISH, 16'hFFFF);          // single sample, no percentiles
        push(FN_NONE, 16'hA5A5);            // unused code, ignored
        drain();
        write_reg(CFG_IN_USE, 7'd4);
        write_reg(CFG_PCT_A, 7'd0);
        write_reg(CFG_PCT_B, 7'd99);
        write_reg(CFG_PCT_C, 7'd127);       // above 99, index clamps
        write_reg(CFG_PCT_D, 7'd50);
        push(FN_ADD, 16'h0000);
        push(FN_ADD, 16'h8000);
        push(FN_ADD, 16'h7FFF);
        push(FN_ADD, 16'h0001);
        push(FN_FINISH, 16'h0000);          // set kept after finish
        push(FN_ADD, 16'h5555);
        push(FN_ADD, 16'hAAAA);
        push(FN_FINISH, 16'h0000);
        push(FN_CLEAR, 16'hFFFF);
        push(FN_FINISH, 16'h0000);          // empty after clear
        drain();
        // pct_in_use above four acts as four
        write_reg(CFG_IN_USE, 7'd7);
        push(FN_ADD, 16'd3);
        push(FN_ADD, 16'd1);
        push(FN_ADD, 16'd2);
        push(FN_FINISH, 16'd0);
        drain();

        // Random phases, each with its own percentile setting
        items = 0;
        while (items < 375) begin
            write_reg(CFG_IN_USE, 7'($urandom_range(0, 7)));
            write_reg(CFG_PCT_A, 7'($urandom_range(0, 127)));
            write_reg(CFG_PCT_B, $urandom_range(0, 1) ? 7'd99 : 7'($urandom_range(0, 99)));
            write_reg(CFG_PCT_C, 7'($urandom_range(0, 99)));
            write_reg(CFG_PCT_D, $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(0, 127)));
            for (int s = 0; s < 4; s++) begin
                int n;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80) : $urandom_range(0, 12);
                queue_set(n);
                items += n + 2;
                if ($urandom_range(0, 2) == 0) begin
                    push(t_func'($urandom_range(0, 3)), 16'($urandom));   // noise
                    items++;
                end
            end
            drain();
        end

        // Sender holds off until every report is back, then one more set
        hold_sender = 1;
        queue_set(5);
        while (expected_reports.size() != 0) @(posedge i_clk);
        hold_sender = 0;
        drain();

        repeat (50) @(posedge i_clk);
        $display("Covered empty, single-sample and random sets with noise words; %0d reports.",
                 report_count);
        $display("Percentile settings spanned 0..127 and in-use counts 0..7.");
        if (error_count == 0 && expected_reports.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/sse_pkg.sv
rtl/core/sample_statistics_engine_unit.sv
tb/tb_sample_statistics_engine_unit.sv
